// File: rtl/core/cmpr_pkg.sv
// Package with shared constants and types for the confusion-matrix block.
package cmpr_pkg;

    localparam int MAX_CLASSES_DEF = 16;
    localparam int COUNT_WIDTH_DEF = 24;
    localparam int NUM_CLASSES_RESET = 2;
    localparam int Q16_ONE = 65536;
    localparam int FRAC_W = 17;

    typedef enum logic [1:0] {
        MODE_RECORD = 2'd0,
        MODE_RECORD_FINISH = 2'd1,
        MODE_FINISH = 2'd2,
        MODE_UNUSED = 2'd3
    } mode_t;

    typedef enum logic [0:0] {
        REG_NUM_CLASSES = 1'd0
    } reg_index_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_CLEAR,
        BK_SUM,
        BK_DIV,
        BK_OUT
    } back_state_t;

    // Command passed from the front end to the back end.
    typedef struct packed {
        logic       rec;
        logic       fin;
        logic [3:0] pc;
        logic [3:0] tc;
    } cmd_t;

endpackage

// File: rtl/core/cmpr_front.sv
// Front end: accepts items, decodes mode, checks ranges, and queues commands.
module cmpr_front
    import cmpr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] in_mode,
    input  logic [3:0] in_pc,
    input  logic [3:0] in_tc,
    input  logic [4:0] n_eff,
    output logic       q_valid,
    input  logic       q_pop,
    output cmd_t       q_cmd
);

    localparam int DEPTH = 4;

    cmd_t       fifo_reg [DEPTH];
    logic [1:0] wptr_reg, rptr_reg;
    logic [2:0] cnt_reg;
    logic       push;
    cmd_t       cmd_in;
    logic       in_range;

    assign in_ready = (cnt_reg != 3'(DEPTH));
    assign in_range = ({1'b0, in_pc} < n_eff) && ({1'b0, in_tc} < n_eff);

    always_comb
    begin
        cmd_in.pc = in_pc;
        cmd_in.tc = in_tc;
        cmd_in.rec = 1'b0;
        cmd_in.fin = 1'b0;
        case (mode_t'(in_mode))
            MODE_RECORD:
            begin
                cmd_in.rec = in_range;
            end
            MODE_RECORD_FINISH:
            begin
                cmd_in.rec = in_range;
                cmd_in.fin = 1'b1;
            end
            MODE_FINISH:
            begin
                cmd_in.fin = 1'b1;
            end
            default:
            begin
                cmd_in.rec = 1'b0;
            end
        endcase
    end

    assign push = in_valid && in_ready && (cmd_in.rec || cmd_in.fin);
    assign q_valid = (cnt_reg != 3'd0);
    assign q_cmd = fifo_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + 2'd1;
            end
            if (q_pop)
            begin
                rptr_reg <= rptr_reg + 2'd1;
            end
            cnt_reg <= cnt_reg + 3'(push) - 3'(q_pop);
        end
    end

endmodule

// File: rtl/core/cmpr_back.sv
// Back end: counter memory, per-class sums, serial dividers and result register.
module cmpr_back
    import cmpr_pkg::*;
#(
    parameter int MAX_CLASSES = MAX_CLASSES_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    output logic        q_pop,
    input  cmd_t        q_cmd,
    input  logic [4:0]  n_eff,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  out_class,
    output logic [16:0] out_prec,
    output logic [16:0] out_rec,
    output logic [23:0] out_diag,
    output logic        out_last
);

    localparam int IW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int AW = 2 * IW;
    localparam int DEPTH = 1 << AW;
    localparam int SW = COUNT_WIDTH + AW;
    localparam int DW = SW + 16;
    localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

    logic [COUNT_WIDTH-1:0] mem [DEPTH];
    logic [COUNT_WIDTH-1:0] rdata_reg;
    logic [AW-1:0]          raddr, waddr;
    logic                   wen;
    logic [COUNT_WIDTH-1:0] wdata;

    back_state_t state_reg, state_next;

    // Record pipeline: stage 1 reads, stage 2 writes.
    logic          rmw_reg;
    logic [AW-1:0] rmw_addr_reg;
    logic [AW-1:0] clr_reg;
    logic [3:0]    cls_reg;
    logic [4:0]    k_reg;
    logic [1:0]    sub_reg;
    logic [SW-1:0] col_reg, row_reg;
    logic [COUNT_WIDTH-1:0] diag_reg;
    logic [DW-1:0] rem_p_reg, rem_r_reg;
    logic [16:0]   qp_reg, qr_reg;
    logic [5:0]    dstep_reg;
    logic          ovalid_reg;
    logic [3:0]    oclass_reg;
    logic [16:0]   oprec_reg, orec_reg;
    logic [23:0]   odiag_reg;
    logic          olast_reg;

    logic [AW-1:0] cmd_addr;
    logic          rec_go;
    logic [COUNT_WIDTH-1:0] inc_val;
    logic          hazard;

    assign cmd_addr = {IW'(q_cmd.pc), IW'(q_cmd.tc)};
    // Back-to-back hit on the same counter: hold it while stage 2 writes, so the read sees the write.
    assign hazard = rmw_reg && (rmw_addr_reg == cmd_addr);
    assign rec_go = (state_reg == BK_IDLE) && q_valid && !hazard && !q_cmd.fin;
    assign inc_val = (rdata_reg == CMAX) ? rdata_reg : rdata_reg + 1'b1;

    // Sum phase address: sub 0 column entry (k,c), sub 1 row entry (c,k).
    always_comb
    begin
        raddr = cmd_addr;
        if (state_reg == BK_SUM)
        begin
            if (sub_reg[0] == 1'b0)
            begin
                raddr = {IW'(k_reg), IW'(cls_reg)};
            end
            else
            begin
                raddr = {IW'(cls_reg), IW'(k_reg)};
            end
        end
    end

    always_comb
    begin
        wen = 1'b0;
        waddr = rmw_addr_reg;
        wdata = inc_val;
        if (state_reg == BK_CLEAR)
        begin
            wen = 1'b1;
            waddr = clr_reg;
            wdata = '0;
        end
        else if (rmw_reg)
        begin
            wen = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    logic sum_done, div_done, fin_go, out_free;
    // A record-then-finish command first records, then is treated as pure finish.
    logic conv_reg;

    assign fin_go = (state_reg == BK_IDLE) && q_valid && q_cmd.fin && !rmw_reg;
    assign out_free = !ovalid_reg || out_ready;
    assign sum_done = (sub_reg == 2'd2) && (k_reg == n_eff - 5'd1);
    assign div_done = (dstep_reg == 6'd17);

    assign q_pop = rec_go || (fin_go && (!q_cmd.rec || conv_reg));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (fin_go)
                begin
                    state_next = (q_cmd.rec && !conv_reg) ? BK_IDLE : BK_SUM;
                end
            end
            BK_SUM:
            begin
                if (sum_done)
                begin
                    state_next = BK_DIV;
                end
            end
            BK_DIV:
            begin
                if (div_done)
                begin
                    state_next = BK_OUT;
                end
            end
            BK_OUT:
            begin
                if (out_free)
                begin
                    state_next = ({1'b0, cls_reg} == n_eff - 5'd1) ? BK_CLEAR : BK_SUM;
                end
            end
            BK_CLEAR:
            begin
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_CLEAR;
            rmw_reg <= 1'b0;
            rmw_addr_reg <= '0;
            clr_reg <= '0;
            cls_reg <= '0;
            k_reg <= '0;
            sub_reg <= '0;
            dstep_reg <= '0;
            ovalid_reg <= 1'b0;
            conv_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rmw_reg <= rec_go || (fin_go && q_cmd.rec && !conv_reg);
            rmw_addr_reg <= cmd_addr;
            if (fin_go && q_cmd.rec && !conv_reg)
            begin
                conv_reg <= 1'b1;
            end
            if (fin_go && (!q_cmd.rec || conv_reg))
            begin
                conv_reg <= 1'b0;
            end
            if (state_reg == BK_OUT && out_free)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (ovalid_reg && out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
            unique case (state_reg)
                BK_IDLE:
                begin
                    cls_reg <= '0;
                    k_reg <= '0;
                    sub_reg <= '0;
                    clr_reg <= '0;
                end
                BK_SUM:
                begin
                    // sub steps through column read, row read and a spare slot.
                    if (sum_done)
                    begin
                        k_reg <= '0;
                        sub_reg <= '0;
                        dstep_reg <= '0;
                    end
                    else if (sub_reg == 2'd2)
                    begin
                        sub_reg <= 2'd0;
                        k_reg <= k_reg + 5'd1;
                    end
                    else
                    begin
                        sub_reg <= sub_reg + 2'd1;
                    end
                end
                BK_DIV:
                begin
                    dstep_reg <= dstep_reg + 6'd1;
                end
                BK_OUT:
                begin
                    if (out_free)
                    begin
                        cls_reg <= cls_reg + 4'd1;
                    end
                end
                BK_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                end
                default:
                begin
                    cls_reg <= cls_reg;
                end
            endcase
        end
    end

    // For a record-then-finish command, the first fin_go only records (the state
    // stays IDLE and nothing is popped); the next fin_go, with conv set, pops the
    // command and starts the sums.

    // Sum datapath. Reads issued at sub 0 and 1 come back through rdata_reg in the next cycle.
    logic [1:0] sub_d_reg;
    logic       in_sum_d_reg;
    logic [IW-1:0] k_d_reg;
    always_ff @(posedge clk)
    begin
        sub_d_reg <= sub_reg;
        k_d_reg <= IW'(k_reg);
        in_sum_d_reg <= (state_reg == BK_SUM);
        if (state_reg == BK_IDLE)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_sum_d_reg)
        begin
            if (sub_d_reg == 2'd0)
            begin
                col_reg <= col_reg + SW'(rdata_reg);
            end
            else if (sub_d_reg == 2'd1)
            begin
                row_reg <= row_reg + SW'(rdata_reg);
                if (k_d_reg == IW'(cls_reg))
                begin
                    diag_reg <= rdata_reg;
                end
            end
        end
        if (state_reg == BK_OUT && out_free)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        // Restoring division, one quotient bit per step.
        if (state_reg == BK_DIV)
        begin
            if (dstep_reg == 6'd0)
            begin
                rem_p_reg <= '0;
                rem_r_reg <= '0;
                qp_reg <= '0;
                qr_reg <= '0;
            end
            else
            begin
                rem_p_reg <= div_rem(rem_p_reg, col_reg, dstep_reg);
                rem_r_reg <= div_rem(rem_r_reg, row_reg, dstep_reg);
                qp_reg <= {qp_reg[15:0], div_bit(rem_p_reg, col_reg, dstep_reg)};
                qr_reg <= {qr_reg[15:0], div_bit(rem_r_reg, row_reg, dstep_reg)};
            end
        end
        if (state_reg == BK_OUT && out_free)
        begin
            oclass_reg <= cls_reg;
            oprec_reg <= (col_reg == '0) ? 17'(Q16_ONE) : qp_reg;
            orec_reg <= (row_reg == '0) ? 17'(Q16_ONE) : qr_reg;
            odiag_reg <= 24'(diag_reg);
            olast_reg <= ({1'b0, cls_reg} == n_eff - 5'd1);
        end
    end

    // Dividend bits of diag<<16 enter MSB first: high part in one step, then zeros.
    function automatic logic [DW-1:0] shifted(input logic [DW-1:0] rem,
                                              input logic [5:0] step);
        logic [DW-1:0] r;
        r = rem;
        if (step == 6'd1)
        begin
            r = DW'(diag_reg);
        end
        else
        begin
            r = {rem[DW-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic [DW-1:0] div_rem(input logic [DW-1:0] rem,
                                              input logic [SW-1:0] d,
                                              input logic [5:0] step);
        logic [DW-1:0] r;
        r = shifted(rem, step);
        if (r >= DW'(d))
        begin
            r = r - DW'(d);
        end
        return r;
    endfunction

    function automatic logic div_bit(input logic [DW-1:0] rem,
                                     input logic [SW-1:0] d,
                                     input logic [5:0] step);
        logic [DW-1:0] r;
        r = shifted(rem, step);
        return (r >= DW'(d));
    endfunction

    assign out_valid = ovalid_reg;
    assign out_class = oclass_reg;
    assign out_prec = oprec_reg;
    assign out_rec = orec_reg;
    assign out_diag = odiag_reg;
    assign out_last = olast_reg;

endmodule

// File: rtl/core/confusion_matrix_precision_recall.sv
// Top level of the confusion-matrix accumulator with per-class precision and recall.
// Record items pass at one per cycle unless a full queue, a hazard or a finish holds
// them: the front end decodes each into a four-entry queue and the back end does one
// read-modify-write of the counter memory through a two-stage pipeline (a second hit
// on the same counter right behind the first waits until the write is done). A
// record-then-finish item first records its pair, then runs as a finish. A finish item
// runs, per class, sums over the single read port of the memory, a bit-serial division
// (one set-up step and 17 quotient bits) and a load of the result register, which may
// wait on m_tready, followed by a clearing pass over the whole counter memory, one
// counter per cycle (256 counters at the default size). The same clearing pass runs
// right after reset. The queue keeps taking items meanwhile until it fills.
module confusion_matrix_precision_recall
    import cmpr_pkg::*;
#(
    parameter int MAX_CLASSES = MAX_CLASSES_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // mode[1:0], predicted_class[5:2], true_class[9:6]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // class_index[3:0], precision_frac[20:4],
                                   // recall_frac[37:21], diagonal_count[61:38]
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [4:0]  num_classes_reg;
    logic [4:0]  n_eff;
    logic        q_valid, q_pop;
    cmd_t        q_cmd;
    logic [3:0]  o_class;
    logic [16:0] o_prec, o_rec;
    logic [23:0] o_diag;
    localparam int CAP = (MAX_CLASSES < 16) ? MAX_CLASSES : 16;

    assign pready = 1'b1;
    assign prdata = (paddr[1:0] == 2'd0) ? {27'd0, num_classes_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_classes_reg <= 5'(NUM_CLASSES_RESET);
        end
        else if (psel && penable && pwrite && paddr == 2'd0)
        begin
            num_classes_reg <= pwdata[4:0];
        end
    end

    // Clamp the class count to one through the capacity.
    assign n_eff = (num_classes_reg == 5'd0) ? 5'd1 :
                   (num_classes_reg > 5'(CAP)) ? 5'(CAP) : num_classes_reg;

    cmpr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_mode  (s_tdata[1:0]),
        .in_pc    (s_tdata[5:2]),
        .in_tc    (s_tdata[9:6]),
        .n_eff    (n_eff),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_cmd    (q_cmd)
    );

    cmpr_back #(
        .MAX_CLASSES (MAX_CLASSES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_cmd     (q_cmd),
        .n_eff     (n_eff),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_class (o_class),
        .out_prec  (o_prec),
        .out_rec   (o_rec),
        .out_diag  (o_diag),
        .out_last  (m_tlast)
    );

    assign m_tdata = {2'b00, o_diag, o_rec, o_prec, o_class};

endmodule

// File: tb/tb_confusion_matrix_precision_recall.sv
// Testbench for the confusion-matrix accumulator: directed cases and random pair streams checked against a predictor.
module tb_confusion_matrix_precision_recall;
    import cmpr_pkg::*;

    // Shape of one expected result row.
    typedef struct packed {
        logic [3:0]  cls;
        logic [16:0] prec;
        logic [16:0] rec;
        logic [23:0] diag;
        logic        last;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int err_count = 0;

    // Mismatch reporting: one line per problem, and the problem is counted.
    task automatic report(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        err_count++;
    endtask

    // The scoreboard keeps its own copy of the count matrix and class count and
    // queues the result rows that each finish produces.
    class matrix_scoreboard;
        logic [23:0] counts [16][16];
        logic [4:0]  classes_reg;
        row_t        pending_rows[$];

        function void clear_counts();
            foreach (counts[i, j]) counts[i][j] = '0;
        endfunction

        function int active_count();
            int n;
            n = classes_reg;
            if (n < 1) n = 1;
            if (n > 16) n = 16;
            return n;
        endfunction

        // Q1.16 ratio, truncated; an empty sum counts as a ratio of one.
        function logic [16:0] ratio(input longint unsigned part, input longint unsigned whole);
            if (whole == 0) return 17'd65536;
            return 17'((part << 16) / whole);
        endfunction

        function void note_item(input mode_t mode, input int pc, input int tc);
            int n;
            longint unsigned colsum, rowsum, dg;
            row_t r;
            n = active_count();
            if (mode == MODE_UNUSED) return;
            if ((mode == MODE_RECORD || mode == MODE_RECORD_FINISH) && pc < n && tc < n)
                if (counts[pc][tc] != 24'hFFFFFF) counts[pc][tc] = counts[pc][tc] + 1;
            if (mode == MODE_RECORD_FINISH || mode == MODE_FINISH) begin
                for (int c = 0; c < n; c++) begin
                    colsum = 0;
                    rowsum = 0;
                    for (int k = 0; k < n; k++) begin
                        colsum += counts[k][c];
                        rowsum += counts[c][k];
                    end
                    dg = counts[c][c];
                    r.cls = 4'(c);
                    r.prec = ratio(dg, colsum);
                    r.rec = ratio(dg, rowsum);
                    r.diag = 24'(dg);
                    r.last = (c == n - 1);
                    pending_rows.push_back(r);
                end
                clear_counts();
            end
        endfunction

        task check_row(input logic [63:0] data, input logic lst);
            row_t e;
            if (pending_rows.size() == 0) begin
                report($sformatf("unexpected result row %h", data));
                return;
            end
            e = pending_rows.pop_front();
            if (data[3:0] !== e.cls)
                report($sformatf("class_index %0d, want %0d", data[3:0], e.cls));
            if (data[20:4] !== e.prec)
                report($sformatf("class %0d precision %0d, want %0d", e.cls, data[20:4], e.prec));
            if (data[37:21] !== e.rec)
                report($sformatf("class %0d recall %0d, want %0d", e.cls, data[37:21], e.rec));
            if (data[61:38] !== e.diag)
                report($sformatf("class %0d diagonal %0d, want %0d", e.cls, data[61:38], e.diag));
            if (lst !== e.last)
                report($sformatf("class %0d tlast %0b, want %0b", e.cls, lst, e.last));
        endtask
    endclass

    matrix_scoreboard sb;

    confusion_matrix_precision_recall DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Result side: every accepted row goes to the scoreboard. The receiver
    // stalls on its own pattern, with stall-free stretches mixed in.
    int stall_mode = 0;
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (m_tvalid && m_tready) sb.check_row(m_tdata, m_tlast);
            if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ~m_tready;
            endcase
        end
    end

    // A register write: setup cycle, then access cycle.
    task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 2'(idx);
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.classes_reg = value[4:0];
    endtask

    // Send one item and hold it until the block takes it. The predictor is
    // updated at the edge of acceptance, so the class count in force is exact.
    task automatic send_item(input mode_t mode, input int pc, input int tc);
        s_tvalid <= 1'b1;
        s_tdata <= {6'b0, 4'(tc), 4'(pc), 2'(mode)};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_item(mode, pc, tc);
    endtask

    // Sender gap: drop valid for a random number of cycles, or not at all.
    task automatic sender_gap();
        int g;
        g = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
        if (g > 0) begin
            s_tvalid <= 1'b0;
            s_tdata <= 16'($urandom);
            repeat (g) @(posedge clk);
        end
    endtask

    // Wait until every expected row has arrived, then let the clearing pass
    // of the counter memory finish before anything else changes.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending_rows.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    // A burst of random items: mostly well-formed pairs inside the class
    // range, some out of range, an occasional finish and the unused mode.
    task automatic random_run(input int count, input int n);
        int left, k, sel;
        mode_t m;
        left = count;
        while (left > 0) begin
            k = $urandom_range(1, 12);
            while (k > 0 && left > 0) begin
                sel = $urandom_range(0, 99);
                if (sel < 78) m = MODE_RECORD;
                else if (sel < 86) m = MODE_RECORD_FINISH;
                else if (sel < 94) m = MODE_FINISH;
                else m = MODE_UNUSED;
                if ($urandom_range(0, 9) == 0)
                    send_item(m, $urandom_range(0, 15), $urandom_range(0, 15));
                else
                    send_item(m, $urandom_range(0, n - 1), $urandom_range(0, n - 1));
                if (m != MODE_UNUSED) left--;
                k--;
            end
            sender_gap();
        end
    endtask

    initial
    begin
        sb = new();
        sb.clear_counts();
        sb.classes_reg = 5'(NUM_CLASSES_RESET);
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        // Clearing pass after reset.
        repeat (300) @(posedge clk);

        // Directed part at the reset class count: empty finish gives 1.0,
        // perfect diagonal, off-diagonal, out-of-range pair, unused mode.
        send_item(MODE_FINISH, 0, 0);
        send_item(MODE_RECORD, 0, 0);
        send_item(MODE_RECORD, 1, 0);
        send_item(MODE_RECORD, 15, 15);
        send_item(MODE_RECORD, 1, 9);
        send_item(MODE_UNUSED, 1, 1);
        send_item(MODE_RECORD_FINISH, 1, 1);
        send_item(MODE_RECORD_FINISH, 14, 0);
        drain();

        // Largest class count: extremes of both indices and a two-thirds ratio.
        write_reg(REG_NUM_CLASSES, 32'd16);
        send_item(MODE_RECORD, 15, 15);
        send_item(MODE_RECORD, 15, 15);
        send_item(MODE_RECORD, 0, 15);
        send_item(MODE_RECORD, 15, 0);
        send_item(MODE_RECORD, 10, 5);
        send_item(MODE_RECORD_FINISH, 5, 10);
        drain();

        // A register value of zero acts as one class; above the capacity as sixteen.
        write_reg(REG_NUM_CLASSES, 32'd0);
        send_item(MODE_RECORD, 0, 0);
        send_item(MODE_RECORD, 0, 1);
        send_item(MODE_FINISH, 0, 0);
        drain();
        write_reg(REG_NUM_CLASSES, 32'd31);
        send_item(MODE_RECORD, 15, 3);
        send_item(MODE_FINISH, 0, 0);
        drain();

        // Random phases over several class counts.
        write_reg(REG_NUM_CLASSES, 32'd1);
        random_run(15, 1);
        send_item(MODE_FINISH, 0, 0);
        drain();
        write_reg(REG_NUM_CLASSES, 32'd3);
        random_run(30, 3);
        send_item(MODE_FINISH, 0, 0);
        drain();
        write_reg(REG_NUM_CLASSES, 32'd16);
        random_run(30, 16);
        send_item(MODE_FINISH, 0, 0);
        drain();
        write_reg(REG_NUM_CLASSES, 32'd7);
        random_run(25, 7);
        send_item(MODE_FINISH, 0, 0);
        drain();

        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Generous run limit.
    initial
    begin
        #5000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
